// File: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 8;

    // Configuration register indexes.
    localparam int REG_CAP_IDX = 0;

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_e_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_e_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

// File: design/spq_cell.sv
// One slot of the sorted list: holds a key and trades it with its neighbors.
module spq_cell #(
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
    input  logic                aclk,
    input  spq_pkg::cell_ctrl_t ctrl_i,
    input  logic [KEY_BITS-1:0] key_i,
    input  logic                vld_i,
    input  logic                left_ge_i,
    input  logic [KEY_BITS-1:0] left_data_i,
    input  logic [KEY_BITS-1:0] right_data_i,
    output logic [KEY_BITS-1:0] data_o,
    output logic [KEY_BITS-1:0] data_next_o,
    output logic                ge_o,
    output logic                eq_o
);

    logic [KEY_BITS-1:0] data_reg;
    logic [KEY_BITS-1:0] data_next;
    logic                le;

    // An empty slot counts as smaller than any key, so a key lands at the tail.
    assign ge_o = !vld_i || (key_i >= data_reg);
    assign le   = vld_i && (data_reg <= key_i);
    assign eq_o = vld_i && (data_reg == key_i);

    always_comb begin
        data_next = data_reg;
        if (ctrl_i.ins && ge_o) begin
            data_next = left_ge_i ? left_data_i : key_i;
        end else if (ctrl_i.rem && le) begin
            // The list is descending, so every slot from the first match on
            // holds a key no larger than the one removed.
            data_next = right_data_i;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o      = data_reg;
    assign data_next_o = data_next;

endmodule

// File: design/sorted_priority_queue_top.sv
// Sorted priority queue: a row of key cells with a count and a result register.
//
// Requests arrive on the s_ stream: tuser selects insert or remove, tdata holds
// the key. Every request produces exactly one result item on the m_ stream with
// a status code in tuser and the count, head key and head flag in tdata.
// Keys are kept in descending order; an insert goes ahead of equal keys and a
// remove takes the matching key nearest the head.
// All cells compare against the key and shift in the same cycle, so a request
// can be accepted every cycle and its result appears in the output register
// in the cycle after. Throughput is one item per cycle as long as the result is
// taken; while m_tready is low and a result is waiting, s_tready is low.
// The capacity limit is written through the APB port at address 0 and is
// clamped to the number of cells; a limit of zero refuses every insert.
// Reset empties the list, drops the result valid flag and sets the capacity
// limit to the full depth. No clearing pass is needed after reset.
module sorted_priority_queue_top #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   s_tvalid,
    output logic                                                   s_tready,
    input  logic [((KEY_BITS + 7) / 8) * 8 - 1:0]                  s_tdata,  // key
    input  logic [0:0]                                             s_tuser,  // req_type
    output logic                                                   m_tvalid,
    input  logic                                                   m_tready,
    // count, head_key, head_valid
    output logic [(($clog2(DEPTH + 1) + KEY_BITS + 8) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]                                             m_tuser,  // status
    input  logic                                                   psel,
    input  logic                                                   penable,
    input  logic                                                   pwrite,
    input  logic [2:0]                                             paddr,
    input  logic [31:0]                                            pwdata,
    output logic [31:0]                                            prdata,
    output logic                                                   pready
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OUT_W  = CNT_W + KEY_BITS + 1;
    localparam int MDATA_W = ((OUT_W + 7) / 8) * 8;

    logic [CNT_W-1:0]    held_reg;
    logic [CNT_W-1:0]    held_next;
    logic [CNT_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    eff_cap;
    logic                m_tvalid_reg;
    logic [MDATA_W-1:0]  m_tdata_reg;
    logic [MDATA_W-1:0]  m_tdata_next;
    logic [1:0]          m_tuser_reg;
    spq_pkg::status_e_t  status_next;

    logic                accept;
    logic                is_remove;
    logic                full;
    logic                found;
    logic [KEY_BITS-1:0] key;
    spq_pkg::cell_ctrl_t ctrl;

    logic [KEY_BITS-1:0] cell_data [DEPTH];
    logic [KEY_BITS-1:0] cell_next [DEPTH];
    logic [DEPTH-1:0]    cell_ge;
    logic [DEPTH-1:0]    cell_eq;
    logic                cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(DEPTH);
        end else if (cfg_wr && (32'(paddr[2]) == spq_pkg::REG_CAP_IDX)) begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata  = (32'(paddr[2]) == spq_pkg::REG_CAP_IDX) ? 32'(cap_reg) : 32'd0;
    assign eff_cap = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;

    // ---------------- request decode ----------------
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_remove = (s_tuser == spq_pkg::REQ_REMOVE);
    assign key       = s_tdata[KEY_BITS-1:0];
    assign full      = (held_reg >= eff_cap);
    assign found     = |cell_eq;

    assign ctrl.ins = accept && !is_remove && !full;
    assign ctrl.rem = accept && is_remove && found;

    always_comb begin
        if (is_remove) begin
            if (held_reg == '0) begin
                status_next = spq_pkg::ST_EMPTY;
            end else if (!found) begin
                status_next = spq_pkg::ST_NOT_FOUND;
            end else begin
                status_next = spq_pkg::ST_DONE;
            end
        end else begin
            status_next = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
        end
    end

    always_comb begin
        held_next = held_reg;
        if (ctrl.ins) begin
            held_next = held_reg + CNT_W'(1);
        end else if (ctrl.rem) begin
            held_next = held_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

    // ---------------- cell row ----------------
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                left_ge;
        logic [KEY_BITS-1:0] left_data;
        logic [KEY_BITS-1:0] right_data;

        if (i == 0) begin : g_head
            assign left_ge   = 1'b0;
            assign left_data = '0;
        end else begin : g_body
            assign left_ge   = cell_ge[i-1];
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_data = cell_data[i];
        end else begin : g_inner
            assign right_data = cell_data[i+1];
        end

        spq_cell #(
            .KEY_BITS(KEY_BITS)
        ) u_cell (
            .aclk        (aclk),
            .ctrl_i      (ctrl),
            .key_i       (key),
            .vld_i       (CNT_W'(i) < held_reg),
            .left_ge_i   (left_ge),
            .left_data_i (left_data),
            .right_data_i(right_data),
            .data_o      (cell_data[i]),
            .data_next_o (cell_next[i]),
            .ge_o        (cell_ge[i]),
            .eq_o        (cell_eq[i])
        );
    end

    // ---------------- result register ----------------
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[CNT_W-1:0] = held_next;
        if (held_next != '0) begin
            m_tdata_next[CNT_W +: KEY_BITS] = cell_next[0];
            m_tdata_next[OUT_W-1]           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_held_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(DEPTH))
        else $error("held count exceeds the number of cells");

    a_full_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_remove && full) |=> $stable(held_reg))
        else $error("refused insert changed the count");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_remove && found) |=> (held_reg == $past(held_reg) - CNT_W'(1)))
        else $error("successful remove did not lower the count by one");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("new item taken while a result is stalled");

endmodule
